/* hdl/assert_macros.svh */
// assertion macros shared by the allocator modules
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SCB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define SCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/scbpa_pkg.sv */
// shared types, constants and helper functions of the size class pool allocator
// no dependencies; imported by every module of the block
package scbpa_pkg;

    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned NUM_POOLS   = 5;
    localparam int unsigned MAP_W       = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned POOL_W      = 3;
    localparam int unsigned SIZE_W      = 20;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam int unsigned CLASS0_SLOTS   = 16;
    localparam int unsigned CLASS1_SLOTS   = 16;
    localparam int unsigned CLASS2_SLOTS   = 16;
    localparam int unsigned CLASS3_SLOTS   = 16;
    localparam int unsigned FALLBACK_SLOTS = 8;

    localparam int unsigned POOL_SLOTS [NUM_POOLS] = '{
        CLASS0_SLOTS, CLASS1_SLOTS, CLASS2_SLOTS, CLASS3_SLOTS, FALLBACK_SLOTS
    };

    typedef logic [MAP_W-1:0]    t_map;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [POOL_W-1:0]   t_pool;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_pool FB_POOL = t_pool'(NUM_POOLS - 1);

    localparam t_size LIMIT_RESET [NUM_CLASSES] = '{
        t_size'(2048), t_size'(8192), t_size'(32768), t_size'(65536)
    };

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_LAST_LIMIT = t_cfg_idx'(NUM_CLASSES - 1);

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO     = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOT_HELD = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the input transfer
        logic exec;   // run the request, update maps, fill output register
    } t_ctrl_cmd;

    // bits of a map that belong to real slots of pool p
    function automatic t_map pool_mask(input int unsigned p);
        t_map m;
        m = '0;
        for (int unsigned i = 0; i < MAP_W; i++) begin
            m[i] = (i < POOL_SLOTS[p]);
        end
        return m;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic t_slot lowest_set(input t_map v);
        t_slot idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = t_slot'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hdl/size_class_block_pool_allocator_top.sv */
// top level of the size class block pool allocator
// depends on scbpa_pkg, scbpa_ctrl and scbpa_dp
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready   i_func, i_req_size, i_free_class, i_free_slot
//  result    out        o_out_valid / i_out_ready o_status, o_pool_class, o_slot
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// each request is first captured from the transfer, then a separate execute step runs the
// class compares, the priority encoders and the map update; the next request
// is taken while the result still waits in the output register
// a stalled result holds the execute step, so input ready stays low until it moves on
// synchronous active low reset clears all occupancy maps and loads default limits
// config writes are always taken; no clearing pass is needed after reset
module size_class_block_pool_allocator_top
    import scbpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_func,
    input  t_size    i_req_size,
    input  t_pool    i_free_class,
    input  t_slot    i_free_slot,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_status  o_status,
    output t_pool    o_pool_class,
    output t_slot    o_slot,
    // configuration channel
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  t_size    i_cfg_data
);

    t_ctrl_cmd cmd;

    // limit registers can take a write at any cycle
    assign o_cfg_ready = 1'b1;

    // sequencing of request, execute and result transfer
    scbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // limits, occupancy maps, slot search and result register
    scbpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_req_size   (i_req_size),
        .i_free_class (i_free_class),
        .i_free_slot  (i_free_slot),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_status),
        .o_pool_class (o_pool_class),
        .o_slot       (o_slot)
    );

endmodule

/* hdl/scbpa_ctrl.sv */
// controller of the size class pool allocator: request sequencing and output valid
// depends on scbpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module scbpa_ctrl
    import scbpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_blocked;

    assign out_blocked = r_out_valid && !i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!out_blocked) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SCB_ASSERT(a_exec_room, i_clk, i_rst_n, o_cmd.exec |-> !out_blocked, "exec with output full")
    `SCB_ASSERT(a_load_exec, i_clk, i_rst_n, o_cmd.load |=> r_state == S_EXEC, "load without exec")
    `SCB_ASSERT(a_exec_valid, i_clk, i_rst_n, o_cmd.exec |=> r_out_valid, "result lost after exec")
    `SCB_ASSERT_ALWAYS(a_cmd_excl, i_clk, !(o_cmd.load && o_cmd.exec), "load and exec together")

endmodule

/* hdl/scbpa_dp.sv */
// datapath of the size class pool allocator: limits, occupancy maps, output register
// depends on scbpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module scbpa_dp
    import scbpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  logic      i_func,
    input  t_size     i_req_size,
    input  t_pool     i_free_class,
    input  t_slot     i_free_slot,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_index,
    input  t_size     i_cfg_data,
    output t_status   o_status,
    output t_pool     o_pool_class,
    output t_slot     o_slot
);

    // captured request
    logic  r_func;
    t_size r_size;
    t_pool r_fcls;
    t_slot r_fslot;

    t_size r_lim [NUM_CLASSES];
    t_map  r_busy [NUM_POOLS];
    t_map  n_busy [NUM_POOLS];

    t_status r_status, n_status;
    t_pool   r_pool, n_pool;
    t_slot   r_slot, n_slot;

    t_map                   free_vec [NUM_POOLS];
    logic [NUM_POOLS-1:0]   has_free;
    t_slot                  low_idx [NUM_POOLS];
    logic [NUM_CLASSES-1:0] fits_le;
    logic [NUM_CLASSES-1:0] above;
    logic                   granted;
    t_map                   sel_map;
    logic                   fcls_ok;
    logic                   fb_stray;

    always_comb begin
        for (int unsigned p = 0; p < NUM_POOLS; p++) begin
            free_vec[p] = ~r_busy[p] & pool_mask(p);
            has_free[p] = |free_vec[p];
            low_idx[p]  = lowest_set(free_vec[p]);
        end
        for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
            fits_le[c] = (r_size <= r_lim[c]);
        end
        above[0] = 1'b1;
        for (int unsigned c = 1; c < NUM_CLASSES; c++) begin
            above[c] = !fits_le[c-1];
        end
    end

    always_comb begin
        n_busy   = r_busy;
        n_status = ST_OK;
        n_pool   = '0;
        n_slot   = '0;
        granted  = 1'b0;
        fcls_ok  = (r_fcls < t_pool'(NUM_POOLS));
        sel_map  = fcls_ok ? r_busy[r_fcls] : '0;
        if (r_func == FUNC_ALLOC) begin
            if (r_size == '0) begin
                n_status = ST_ZERO;
            end else begin
                // first class in ascending order whose bracket holds the size and has room
                for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
                    if (!granted && above[c] && fits_le[c] && has_free[c]) begin
                        granted                 = 1'b1;
                        n_pool                  = t_pool'(c);
                        n_slot                  = low_idx[c];
                        n_busy[c][low_idx[c]]   = 1'b1;
                    end
                end
                if (!granted) begin
                    if (has_free[FB_POOL]) begin
                        n_pool                        = FB_POOL;
                        n_slot                        = low_idx[FB_POOL];
                        n_busy[FB_POOL][low_idx[FB_POOL]] = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
        end else begin
            // busy bits exist only for real slots, so this also rejects out of range slots
            n_pool = r_fcls;
            n_slot = r_fslot;
            if (fcls_ok && sel_map[r_fslot]) begin
                n_busy[r_fcls][r_fslot] = 1'b0;
            end else begin
                n_status = ST_NOT_HELD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_size  <= i_req_size;
            r_fcls  <= i_free_class;
            r_fslot <= i_free_slot;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pool   <= n_pool;
            r_slot   <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
                r_lim[c] <= LIMIT_RESET[c];
            end
            for (int unsigned p = 0; p < NUM_POOLS; p++) begin
                r_busy[p] <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_index <= CFG_LAST_LIMIT)) begin
                r_lim[i_cfg_index[1:0]] <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_busy <= n_busy;
            end
        end
    end

    assign o_status     = r_status;
    assign o_pool_class = r_pool;
    assign o_slot       = r_slot;

    // busy bit set past the end of the fallback pool
    assign fb_stray = |(r_busy[FB_POOL] & ~pool_mask(FB_POOL));

    `SCB_ASSERT(a_fb_in_range, i_clk, i_rst_n, !fb_stray, "fallback slot beyond pool size busy")
    `SCB_ASSERT(a_map_hold, i_clk, i_rst_n, !i_cmd.exec |=> $stable(r_busy[0]), "class 0 map moved")

endmodule
